/* rtl/core/ptg_pkg.sv */
// Shared types and constants of the pulse train generator.
package ptg_pkg;

    // Width of the time registers in the configuration set
    localparam int unsigned REG_W = 15;

    // Width of the random word and of the divider
    localparam int unsigned RND_W = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_CYCLE_LIMIT   = 3'd0;
    localparam logic [2:0] REG_ON_TIME       = 3'd1;
    localparam logic [2:0] REG_OFF_TIME      = 3'd2;
    localparam logic [2:0] REG_START_DELAY   = 3'd3;
    localparam logic [2:0] REG_AUTO_WAIT_MIN = 3'd4;
    localparam logic [2:0] REG_AUTO_WAIT_MAX = 3'd5;
    localparam logic [2:0] REG_COUPLE_ENABLE = 3'd6;

    // Configuration reset values
    localparam logic [REG_W-1:0] RST_CYCLE_LIMIT   = 15'd1;
    localparam logic [REG_W-1:0] RST_ON_TIME       = 15'd100;
    localparam logic [REG_W-1:0] RST_OFF_TIME      = 15'd100;
    localparam logic [REG_W-1:0] RST_START_DELAY   = 15'd0;
    localparam logic [REG_W-1:0] RST_AUTO_WAIT_MIN = 15'd1000;
    localparam logic [REG_W-1:0] RST_AUTO_WAIT_MAX = 15'd5000;

    // Item actions
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_START    = 2'd1,
        ACT_AUTO_ON  = 2'd2,
        ACT_AUTO_OFF = 2'd3
    } ptg_action_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ptg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;
    } ptg_sts_t;

endpackage

/* rtl/core/ptg_ctrl.sv */
// Controller state machine of the pulse train generator.
module ptg_ctrl
    import ptg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  ptg_sts_t sts,
    output ptg_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // The output slot can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/ptg_dpath.sv */
// Datapath of the pulse train generator: configuration, train state,
// serial wait divider and the result register.
module ptg_dpath
    import ptg_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ptg_cmd_t         cmd,
    output ptg_sts_t         sts,
    input  logic             cfg_valid,
    input  logic [2:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    input  logic [1:0]       action,
    input  logic [RND_W-1:0] random_value,
    output logic             laser_level,
    output logic             report_valid,
    output logic             report_state,
    output logic [REG_W-1:0] report_duration,
    output logic             coupled_start,
    output logic             train_active
);

    // Comparisons run at the wider of the clock and register widths.
    localparam int unsigned CMP_W = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;
    localparam int unsigned CNT_W = $clog2(RND_W);

    typedef logic [TIME_WIDTH-1:0] tclk_t;

    // Configuration registers
    logic [REG_W-1:0] cycle_limit_reg, on_time_reg, off_time_reg, start_delay_reg;
    logic [REG_W-1:0] wait_min_reg, wait_max_reg;
    logic             couple_en_reg;

    // Train state
    logic             active_reg, delay_pend_reg, start_pend_reg, out_high_reg;
    logic [REG_W-1:0] cycles_done_reg;
    tclk_t            phase_clk_reg, delay_clk_reg, auto_clk_reg;
    logic             auto_en_reg;
    logic [REG_W-1:0] auto_wait_reg;

    // Latched item and divider
    ptg_action_t      action_reg;
    logic [RND_W-1:0] rnd_shift_reg;
    logic [RND_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;

    // Next values computed on commit
    logic             active_next, delay_pend_next, start_pend_next, out_high_next;
    logic [REG_W-1:0] cycles_done_next;
    tclk_t            phase_clk_next, delay_clk_next, auto_clk_next;
    logic             auto_en_next;
    logic [REG_W-1:0] auto_wait_next;
    logic             edge_hit, edge_level, coupled;
    logic [REG_W-1:0] duration;

    logic             bounds_inverted;
    logic [RND_W-1:0] span;
    logic [RND_W:0]   rem_shifted;
    logic [REG_W-1:0] drawn_wait;
    logic             run;

    // Configuration writes; values are truncated to the register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_limit_reg <= RST_CYCLE_LIMIT;
            on_time_reg     <= RST_ON_TIME;
            off_time_reg    <= RST_OFF_TIME;
            start_delay_reg <= RST_START_DELAY;
            wait_min_reg    <= RST_AUTO_WAIT_MIN;
            wait_max_reg    <= RST_AUTO_WAIT_MAX;
            couple_en_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CYCLE_LIMIT:   cycle_limit_reg <= cfg_data;
                REG_ON_TIME:       on_time_reg     <= cfg_data;
                REG_OFF_TIME:      off_time_reg    <= cfg_data;
                REG_START_DELAY:   start_delay_reg <= cfg_data;
                REG_AUTO_WAIT_MIN: wait_min_reg    <= cfg_data;
                REG_AUTO_WAIT_MAX: wait_max_reg    <= cfg_data;
                REG_COUPLE_ENABLE: couple_en_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Wait span; the divider result is only used when the bounds are in order.
    assign bounds_inverted = (wait_max_reg < wait_min_reg);
    assign span = RND_W'(wait_max_reg) - RND_W'(wait_min_reg) + RND_W'(1);

    // One restoring division step per cycle: remainder of random_value by span
    assign rem_shifted = {rem_reg, rnd_shift_reg[RND_W-1]};

    always_comb
    begin
        if (rem_shifted >= {1'b0, span})
        begin
            rem_next = RND_W'(rem_shifted - {1'b0, span});
        end
        else
        begin
            rem_next = rem_shifted[RND_W-1:0];
        end
    end

    assign sts.div_last = (cnt_reg == CNT_W'(RND_W - 1));

    // The remainder is below span, so the sum stays within the maximum.
    assign drawn_wait = bounds_inverted ? wait_min_reg
                                        : wait_min_reg + rem_reg[REG_W-1:0];

    // Item latch and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg    <= ptg_action_t'(action);
            rnd_shift_reg <= random_value;
            rem_reg       <= '0;
            cnt_reg       <= '0;
        end
        else if (cmd.step)
        begin
            rnd_shift_reg <= {rnd_shift_reg[RND_W-2:0], 1'b0};
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_reg + CNT_W'(1);
        end
    end

    // Item update of the train state
    always_comb
    begin
        active_next      = active_reg;
        delay_pend_next  = delay_pend_reg;
        start_pend_next  = start_pend_reg;
        out_high_next    = out_high_reg;
        cycles_done_next = cycles_done_reg;
        phase_clk_next   = phase_clk_reg;
        delay_clk_next   = delay_clk_reg;
        auto_clk_next    = auto_clk_reg;
        auto_en_next     = auto_en_reg;
        auto_wait_next   = auto_wait_reg;
        edge_hit         = 1'b0;
        edge_level       = 1'b0;
        duration         = '0;
        coupled          = 1'b0;
        run              = 1'b0;
        case (action_reg)
            ACT_START:
            begin
                coupled          = couple_en_reg;
                active_next      = 1'b1;
                start_pend_next  = 1'b1;
                cycles_done_next = '0;
                out_high_next    = 1'b0;
                phase_clk_next   = '0;
                delay_pend_next  = (start_delay_reg != '0);
                delay_clk_next   = '0;
            end
            ACT_AUTO_ON:
            begin
                auto_en_next   = 1'b1;
                auto_clk_next  = '0;
                auto_wait_next = drawn_wait;
            end
            ACT_AUTO_OFF:
            begin
                auto_en_next = 1'b0;
            end
            default:
            begin
                // Saturating clocks
                phase_clk_next = (&phase_clk_reg) ? phase_clk_reg
                                                  : phase_clk_reg + tclk_t'(1);
                delay_clk_next = (&delay_clk_reg) ? delay_clk_reg
                                                  : delay_clk_reg + tclk_t'(1);
                auto_clk_next  = (&auto_clk_reg) ? auto_clk_reg
                                                 : auto_clk_reg + tclk_t'(1);

                // Automatic restart once the wait has been exceeded
                if (auto_en_reg && (CMP_W'(auto_clk_next) > CMP_W'(auto_wait_reg)))
                begin
                    coupled          = couple_en_reg;
                    active_next      = 1'b1;
                    start_pend_next  = 1'b1;
                    cycles_done_next = '0;
                    out_high_next    = 1'b0;
                    phase_clk_next   = '0;
                    delay_pend_next  = (start_delay_reg != '0);
                    delay_clk_next   = '0;
                    auto_wait_next   = drawn_wait;
                    auto_clk_next    = '0;
                end

                // Pulse logic of an active train
                if (active_next)
                begin
                    run = 1'b1;
                    if (cycles_done_next >= cycle_limit_reg)
                    begin
                        active_next = 1'b0;
                        run         = 1'b0;
                    end
                    if (run && delay_pend_next)
                    begin
                        if (CMP_W'(delay_clk_next) < CMP_W'(start_delay_reg))
                        begin
                            run = 1'b0;
                        end
                        else
                        begin
                            delay_pend_next = 1'b0;
                        end
                    end
                    if (run)
                    begin
                        if (start_pend_next || (!out_high_next &&
                            (CMP_W'(phase_clk_next) >= CMP_W'(off_time_reg))))
                        begin
                            edge_hit        = 1'b1;
                            edge_level      = 1'b1;
                            duration        = on_time_reg;
                            out_high_next   = 1'b1;
                            start_pend_next = 1'b0;
                            phase_clk_next  = '0;
                        end
                        else if (out_high_next &&
                                 (CMP_W'(phase_clk_next) >= CMP_W'(on_time_reg)))
                        begin
                            edge_hit         = 1'b1;
                            edge_level       = 1'b0;
                            duration         = off_time_reg;
                            out_high_next    = 1'b0;
                            cycles_done_next = cycles_done_next + REG_W'(1);
                            phase_clk_next   = '0;
                        end
                    end
                end
            end
        endcase
    end

    // Train state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            delay_pend_reg  <= 1'b0;
            start_pend_reg  <= 1'b0;
            out_high_reg    <= 1'b0;
            cycles_done_reg <= '0;
            phase_clk_reg   <= '0;
            delay_clk_reg   <= '0;
            auto_clk_reg    <= '0;
            auto_en_reg     <= 1'b0;
            auto_wait_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            active_reg      <= active_next;
            delay_pend_reg  <= delay_pend_next;
            start_pend_reg  <= start_pend_next;
            out_high_reg    <= out_high_next;
            cycles_done_reg <= cycles_done_next;
            phase_clk_reg   <= phase_clk_next;
            delay_clk_reg   <= delay_clk_next;
            auto_clk_reg    <= auto_clk_next;
            auto_en_reg     <= auto_en_next;
            auto_wait_reg   <= auto_wait_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            laser_level     <= out_high_next;
            report_valid    <= edge_hit;
            report_state    <= edge_level;
            report_duration <= duration;
            coupled_start   <= coupled;
            train_active    <= active_next;
        end
    end

endmodule

/* rtl/core/pulse_train_generator_auto_trigger_unit.sv */
// Top level of the delayed pulse train generator with automatic restart.
// Each accepted transaction is loaded, passed through the 16-step serial divider
// that draws the random wait (one remainder bit per cycle) and then applied;
// a new transaction is taken only after the result of the last one is committed.
// A stalled result holds the block in its apply step until the slot frees.
// Reset (asynchronous, active low) restores register defaults and clears state.
module pulse_train_generator_auto_trigger_unit
    import ptg_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [RND_W-1:0] random_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             laser_level,
    output logic             report_valid,
    output logic             report_state,
    output logic [REG_W-1:0] report_duration,
    output logic             coupled_start,
    output logic             train_active,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_data
);

    ptg_cmd_t cmd;
    ptg_sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    ptg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ptg_dpath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .action          (action),
        .random_value    (random_value),
        .laser_level     (laser_level),
        .report_valid    (report_valid),
        .report_state    (report_state),
        .report_duration (report_duration),
        .coupled_start   (coupled_start),
        .train_active    (train_active)
    );

endmodule

/* rtl/core/ptg_chk.sv */
// Port checker of the pulse train generator and its bind to the top level.
module ptg_chk
    import ptg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             laser_level,
    input logic             report_valid,
    input logic             report_state,
    input logic [REG_W-1:0] report_duration
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new transaction taken while an item is in progress");

    // A reported edge leaves the output at the reported level.
    a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_valid |-> laser_level == report_state)
        else $error("edge report disagrees with output level");

    // Without an edge the report fields are zero.
    a_no_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !report_valid |-> !report_state && report_duration == '0)
        else $error("report fields set without an edge");

endmodule

bind pulse_train_generator_auto_trigger_unit ptg_chk u_ptg_chk (.*);

/* dv/testbench.sv */
// Self-checking testbench for the pulse train generator with automatic restart.
`timescale 1ns / 1ps

module testbench;
    import ptg_pkg::*;

    localparam int unsigned TICK_W          = 16;
    localparam int unsigned IDLE_PERCENT    = 32;
    localparam int unsigned PHASE_ITEMS     = 115;
    localparam int unsigned RANDOM_PHASES   = 12;
    localparam int unsigned STEADY_PHASE    = 4;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned WATCHDOG_CYCLES = 500000;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam logic [2:0]  REG_UNUSED      = 3'd7;
    localparam logic [REG_W-1:0] TIME_MAX   = '1;

    // One input transaction as the generator sees it.
    typedef struct packed {
        ptg_action_t      act;
        logic [RND_W-1:0] rnd;
    } pulse_cmd_t;

    // One output transaction; field order follows the output ports.
    typedef struct packed {
        logic             level;
        logic             edge_valid;
        logic             edge_level;
        logic [REG_W-1:0] edge_length;
        logic             coupled;
        logic             running;
    } pulse_report_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       action = ACT_TICK;
    logic [RND_W-1:0] random_value = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             laser_level;
    logic             report_valid;
    logic             report_state;
    logic [REG_W-1:0] report_duration;
    logic             coupled_start;
    logic             train_active;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [2:0]       cfg_index = REG_CYCLE_LIMIT;
    logic [REG_W-1:0] cfg_data = '0;

    pulse_cmd_t    queued_cmds[$];
    pulse_report_t pending_reports[$];
    pulse_cmd_t    driven_cmd = '0;
    logic          steady = 1'b0;
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;

    // Copy of the configuration registers.
    logic [REG_W-1:0] lim_cycles, len_on, len_off, len_delay, wait_lo, wait_hi;
    logic             couple_on;

    // Copy of the generator state.
    logic              train_on, delay_armed, first_pulse, level_high, auto_armed;
    logic [REG_W-1:0]  pulses_done, auto_wait_ticks;
    logic [TICK_W-1:0] phase_ticks, delay_ticks, auto_ticks;

    pulse_train_generator_auto_trigger_unit #(
        .TIME_WIDTH(TICK_W)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .random_value   (random_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .laser_level    (laser_level),
        .report_valid   (report_valid),
        .report_state   (report_state),
        .report_duration(report_duration),
        .coupled_start  (coupled_start),
        .train_active   (train_active),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Random back-pressure and gaps, switched off during the steady phase.
    function automatic logic idle_roll();
        return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // New automatic wait: minimum plus the random word modulo the span.
    function automatic logic [REG_W-1:0] draw_auto_wait(input logic [RND_W-1:0] rnd);
        int unsigned span;
        if (wait_hi < wait_lo)
            return wait_lo;
        span = 32'(wait_hi) - 32'(wait_lo) + 1;
        return REG_W'(32'(wait_lo) + 32'(rnd) % span);
    endfunction

    function automatic void arm_train();
        train_on    = 1'b1;
        first_pulse = 1'b1;
        pulses_done = '0;
        level_high  = 1'b0;
        phase_ticks = '0;
        delay_armed = (len_delay != '0);
        delay_ticks = '0;
    endfunction

    // Advances the generator by one transaction and returns what it should report.
    function automatic pulse_report_t step_generator(input pulse_cmd_t cmd);
        pulse_report_t r;
        logic          go;
        r = '0;
        case (cmd.act)
            ACT_START:
            begin
                r.coupled = couple_on;
                arm_train();
            end
            ACT_AUTO_ON:
            begin
                auto_armed      = 1'b1;
                auto_ticks      = '0;
                auto_wait_ticks = draw_auto_wait(cmd.rnd);
            end
            ACT_AUTO_OFF:
                auto_armed = 1'b0;
            ACT_TICK:
            begin
                phase_ticks = sat_inc(phase_ticks);
                delay_ticks = sat_inc(delay_ticks);
                auto_ticks  = sat_inc(auto_ticks);
                // The automatic restart fires before the pulse logic runs.
                if (auto_armed && auto_ticks > auto_wait_ticks)
                begin
                    r.coupled = couple_on;
                    arm_train();
                    auto_wait_ticks = draw_auto_wait(cmd.rnd);
                    auto_ticks      = '0;
                end
                if (train_on)
                begin
                    go = 1'b1;
                    if (pulses_done >= lim_cycles)
                    begin
                        train_on = 1'b0;
                        go       = 1'b0;
                    end
                    if (go && delay_armed)
                    begin
                        if (delay_ticks < len_delay)
                            go = 1'b0;
                        else
                            delay_armed = 1'b0;
                    end
                    if (go)
                    begin
                        if ((!level_high && phase_ticks >= len_off) || first_pulse)
                        begin
                            r.edge_valid  = 1'b1;
                            r.edge_level  = 1'b1;
                            r.edge_length = len_on;
                            level_high    = 1'b1;
                            first_pulse   = 1'b0;
                            phase_ticks   = '0;
                        end
                        else if (level_high && phase_ticks >= len_on)
                        begin
                            r.edge_valid  = 1'b1;
                            r.edge_level  = 1'b0;
                            r.edge_length = len_off;
                            level_high    = 1'b0;
                            pulses_done   = pulses_done + 1'b1;
                            phase_ticks   = '0;
                        end
                    end
                end
            end
        endcase
        r.level   = level_high;
        r.running = train_on;
        return r;
    endfunction

    // Tracks register writes as the block accepts them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_cycles <= RST_CYCLE_LIMIT;
            len_on     <= RST_ON_TIME;
            len_off    <= RST_OFF_TIME;
            len_delay  <= RST_START_DELAY;
            wait_lo    <= RST_AUTO_WAIT_MIN;
            wait_hi    <= RST_AUTO_WAIT_MAX;
            couple_on  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CYCLE_LIMIT:   lim_cycles <= cfg_data;
                REG_ON_TIME:       len_on     <= cfg_data;
                REG_OFF_TIME:      len_off    <= cfg_data;
                REG_START_DELAY:   len_delay  <= cfg_data;
                REG_AUTO_WAIT_MIN: wait_lo    <= cfg_data;
                REG_AUTO_WAIT_MAX: wait_hi    <= cfg_data;
                REG_COUPLE_ENABLE: couple_on  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Input driver: predicts each accepted transaction, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin : driver_proc
        pulse_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            action       <= ACT_TICK;
            random_value <= '0;
            train_on     = 1'b0;
            delay_armed  = 1'b0;
            first_pulse  = 1'b0;
            level_high   = 1'b0;
            auto_armed   = 1'b0;
            pulses_done  = '0;
            auto_wait_ticks = '0;
            phase_ticks  = '0;
            delay_ticks  = '0;
            auto_ticks   = '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_reports.push_back(step_generator(driven_cmd));
            if (!in_valid || !in_stall)
            begin
                if (queued_cmds.size() != 0 && !idle_roll())
                begin
                    nxt = queued_cmds.pop_front();
                    driven_cmd   <= nxt;
                    action       <= nxt.act;
                    random_value <= nxt.rnd;
                    in_valid     <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random stalls and comparison with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        pulse_report_t seen, want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {laser_level, report_valid, report_state, report_duration,
                        coupled_start, train_active};
                if (pending_reports.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("Unexpected transaction at %0t: level=%0d edge=%0d",
                                 $realtime, seen.level, seen.edge_valid);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (seen !== want)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("Mismatch at %0t", $realtime);
                            $display("  expected level=%0d edge=%0d state=%0d duration=%0d",
                                     want.level, want.edge_valid, want.edge_level,
                                     want.edge_length);
                            $display("           coupled=%0d active=%0d",
                                     want.coupled, want.running);
                            $display("  actual   level=%0d edge=%0d state=%0d duration=%0d",
                                     seen.level, seen.edge_valid, seen.edge_level,
                                     seen.edge_length);
                            $display("           coupled=%0d active=%0d",
                                     seen.coupled, seen.running);
                        end
                    end
                end
            end
            out_stall <= idle_roll();
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == WATCHDOG_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void queue_cmd(input ptg_action_t a, input logic [RND_W-1:0] r);
        queued_cmds.push_back('{act: a, rnd: r});
    endfunction

    // Mostly ticks, so that trains and automatic restarts run their course.
    function automatic pulse_cmd_t random_cmd();
        pulse_cmd_t  c;
        int unsigned r;
        r     = $urandom_range(0, 99);
        c.rnd = RND_W'($urandom);
        if (r < 72)
            c.act = ACT_TICK;
        else if (r < 84)
            c.act = ACT_START;
        else if (r < 93)
            c.act = ACT_AUTO_ON;
        else
            c.act = ACT_AUTO_OFF;
        return c;
    endfunction

    // Register value: mostly small so that edges happen, sometimes an extreme.
    function automatic logic [REG_W-1:0] pick_time(input int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return TIME_MAX;
        if (r == 2)
            return REG_W'($urandom);
        return REG_W'($urandom_range(0, top));
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_registers(input logic [REG_W-1:0] cycles, input logic [REG_W-1:0] on,
                                     input logic [REG_W-1:0] off, input logic [REG_W-1:0] delay,
                                     input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                                     input logic [REG_W-1:0] couple);
        write_register(REG_CYCLE_LIMIT, cycles);
        write_register(REG_ON_TIME, on);
        write_register(REG_OFF_TIME, off);
        write_register(REG_START_DELAY, delay);
        write_register(REG_AUTO_WAIT_MIN, lo);
        write_register(REG_AUTO_WAIT_MAX, hi);
        write_register(REG_COUPLE_ENABLE, couple);
        // An index past the register list must change nothing.
        write_register(REG_UNUSED, REG_W'($urandom));
    endtask

    // Waits until every transaction has been sent and every result has come back.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (queued_cmds.size() != 0 || in_valid || pending_reports.size() != 0);
    endtask

    initial
    begin : sequencer
        int unsigned phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults: immediate first pulse, one auto enable and stop.
        @(negedge clk);
        queue_cmd(ACT_TICK, 16'h0000);
        queue_cmd(ACT_START, 16'hFFFF);
        queue_cmd(ACT_TICK, 16'h0000);
        queue_cmd(ACT_TICK, 16'hFFFF);
        queue_cmd(ACT_AUTO_ON, 16'hFFFF);
        queue_cmd(ACT_AUTO_OFF, 16'h0000);
        wait_idle();

        // Start delay, two short cycles, end of train, inverted wait bounds,
        // automatic restart with coupling, re-enable and stop during a train.
        program_registers(15'd2, 15'd1, 15'd0, 15'd3, 15'd4, 15'd2, 15'h7FFF);
        @(negedge clk);
        queue_cmd(ACT_START, 16'h0000);
        repeat (7) queue_cmd(ACT_TICK, 16'hFFFF);
        queue_cmd(ACT_AUTO_ON, 16'hFFFF);
        repeat (5) queue_cmd(ACT_TICK, 16'h0000);
        queue_cmd(ACT_AUTO_ON, 16'h0000);
        queue_cmd(ACT_AUTO_OFF, 16'hFFFF);
        repeat (2) queue_cmd(ACT_TICK, 16'h0000);

        // Random phases, the first two with every register at an extreme.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            if (phase == 0)
                program_registers('0, '0, '0, '0, '0, '0, 15'h7FFE);
            else if (phase == 1)
                program_registers(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                  TIME_MAX, TIME_MAX);
            else
                program_registers(pick_time(3), pick_time(5), pick_time(5), pick_time(4),
                                  pick_time(12), pick_time(12), REG_W'($urandom));
            @(negedge clk);
            steady = (phase == STEADY_PHASE);
            repeat (PHASE_ITEMS) queued_cmds.push_back(random_cmd());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
